// ===== rtl/phsc_pkg.sv =====
// Package for the polygon half-space clipper: shared types, constants and
// the queue entry that passes clip work from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package phsc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int T_BITS        = 30;
    localparam int DIST_W        = 34;
    localparam int CNT_W         = 12;
    localparam int MIN_KEPT      = 3;
    localparam int MAX_POLYGON_POINTS = 2048;
    localparam int COUNT_CAP     = (MAX_POLYGON_POINTS < 4095) ? MAX_POLYGON_POINTS : 4095;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [2:0] REG_INWARD_X  = 3'd3;
    localparam logic [2:0] REG_INWARD_Y  = 3'd4;
    localparam logic [2:0] REG_INWARD_Z  = 3'd5;
    localparam logic [2:0] REG_OFFSET    = 3'd6;
    localparam logic [2:0] REG_TOLERANCE = 3'd7;

    // result kinds on tuser
    localparam logic ITEM_POINT  = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic [2:0][31:0] origin;
        logic [2:0][17:0] inward;
        logic [31:0]      offset;
        logic [15:0]      tol;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_POINT,
        OP_CROSS,
        OP_STATUS
    } op_kind_t;

    // one unit of work for the back end
    typedef struct packed {
        op_kind_t         kind;
        vec3_t            a;
        vec3_t            b;
        logic [DIST_W-1:0] na;
        logic [DIST_W-1:0] nb;
        logic             few;
        logic [CNT_W-1:0] count;
        logic             last;
    } entry_t;

endpackage

// ===== rtl/polygon_half_space_clip.sv =====
// Top level of the polygon half-space clipper: configuration registers,
// front end, work queue and back end. Depends on phsc_pkg, phsc_front,
// phsc_queue and phsc_back.
`timescale 1ns / 1ps

// Clips one closed polygon against a plane half-space in Q16.16. In the front
// end a vertex passes the accept state, the multiply-accumulate steps for the
// distance, a step to offset and saturate, a step to classify both edges, and
// five queue steps, one per possible result whether or not it is produced; a
// full work queue holds the front end longer. Each crossing point passes the
// back end's queue pop, the radix-2 divider, the shared interpolation
// multiplier and the load of the output register. A vertex that produces
// crossings is thus held by the back end's divider, and the front end takes no
// new vertex until the last one's queue steps are done. The status beat
// follows on tlast of the closing vertex run.
module polygon_half_space_clip
    import phsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic         s_tlast,   // closes_polygon
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // point_x, point_y, point_z, too_few_points,
                                    // kept_count, 3 zero bits
    output logic         m_tuser,   // item_kind
    output logic         m_tlast,   // last_of_run
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cfg_t   cfg_reg;
    logic   q_push;
    entry_t q_entry;
    logic   q_full;
    logic   q_pop;
    entry_t q_head;
    logic   q_empty;
    vec3_t  in_vertex;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{origin: '0,
                         inward: {18'd65536, 18'd0, 18'd0},
                         offset: '0,
                         tol:    16'd1};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:  cfg_reg.origin[0] <= cfg_data;
                REG_ORIGIN_Y:  cfg_reg.origin[1] <= cfg_data;
                REG_ORIGIN_Z:  cfg_reg.origin[2] <= cfg_data;
                REG_INWARD_X:  cfg_reg.inward[0] <= cfg_data[17:0];
                REG_INWARD_Y:  cfg_reg.inward[1] <= cfg_data[17:0];
                REG_INWARD_Z:  cfg_reg.inward[2] <= cfg_data[17:0];
                REG_OFFSET:    cfg_reg.offset    <= cfg_data;
                REG_TOLERANCE: cfg_reg.tol       <= cfg_data[15:0];
                default:       cfg_reg.tol       <= cfg_reg.tol;
            endcase
        end
    end

    assign in_vertex = {s_tdata[95:64], s_tdata[63:32], s_tdata[31:0]};

    phsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_vertex (in_vertex),
        .in_closes (s_tlast),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .q_full    (q_full)
    );

    phsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    phsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/phsc_queue.sv =====
// Two-entry queue between the clipper front end and back end.
// Depends on phsc_pkg (entry_t).
`timescale 1ns / 1ps

module phsc_queue
    import phsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/phsc_front.sv =====
// Clipper front end: accepts vertices, computes the signed plane distance,
// classifies both edges and queues point, crossing and status work.
// Depends on phsc_pkg.
`timescale 1ns / 1ps

module phsc_front
    import phsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  vec3_t       in_vertex,
    input  logic        in_closes,
    output logic        q_push,
    output entry_t      q_entry,
    input  logic        q_full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_DIST,
        F_CLASS,
        F_PUSH
    } fstate_t;

    fstate_t                  state_reg;
    vec3_t                    v_reg;
    logic                     closes_reg;
    logic [1:0]               mcnt_reg;
    logic signed [50:0]       prod_reg;
    logic signed [52:0]       acc_reg;
    logic signed [DIST_W-1:0] d_reg;
    vec3_t                    first_v_reg;
    logic signed [DIST_W-1:0] first_d_reg;
    vec3_t                    prev_v_reg;
    logic signed [DIST_W-1:0] prev_d_reg;
    logic                     have_first_reg;
    logic [CNT_W-1:0]         cnt_reg;
    vec3_t                    e1a_reg;
    logic signed [DIST_W-1:0] e1d_reg;
    vec3_t                    e2b_reg;
    logic signed [DIST_W-1:0] e2d_reg;
    logic [4:0]               mask_reg;
    logic [2:0]               step_reg;

    // keep test and strict band crossing, compared on 35 bits
    function automatic logic keep_f(logic signed [DIST_W-1:0] d, logic [15:0] tol);
        logic signed [DIST_W:0] ntol;
        ntol = -$signed({{(DIST_W-15){1'b0}}, tol});
        return $signed({d[DIST_W-1], d}) >= ntol;
    endfunction

    function automatic logic cross_f(logic signed [DIST_W-1:0] da,
                                     logic signed [DIST_W-1:0] db, logic [15:0] tol);
        logic signed [DIST_W:0] ptol;
        logic signed [DIST_W:0] ntol;
        logic signed [DIST_W:0] xa;
        logic signed [DIST_W:0] xb;
        ptol = $signed({{(DIST_W-15){1'b0}}, tol});
        ntol = -ptol;
        xa   = $signed({da[DIST_W-1], da});
        xb   = $signed({db[DIST_W-1], db});
        return ((xa > ptol) && (xb < ntol)) || ((xa < ntol) && (xb > ptol));
    endfunction

    function automatic logic [DIST_W-1:0] abs_f(logic signed [DIST_W-1:0] d);
        return d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
    endfunction

    // one dot product term per cycle
    logic [1:0]         midx;
    logic signed [32:0] diff;
    logic signed [17:0] inw;
    assign midx = (mcnt_reg == 2'd3) ? 2'd2 : mcnt_reg;
    assign diff = $signed({v_reg[midx][31], v_reg[midx]})
                - $signed({cfg.origin[midx][31], cfg.origin[midx]});
    assign inw  = $signed(cfg.inward[midx]);

    // floor shift, offset, saturate
    logic signed [37:0] q_full_w;
    logic signed [DIST_W-1:0] d_sat;
    assign q_full_w = $signed({acc_reg[52], acc_reg[52:FRACTION_BITS]})
                    - $signed({{6{cfg.offset[31]}}, cfg.offset});
    always_comb
    begin
        if (q_full_w > 38'sh1_FFFF_FFFF)
        begin
            d_sat = {1'b0, {(DIST_W-1){1'b1}}};
        end
        else if (q_full_w < -38'sh2_0000_0000)
        begin
            d_sat = {1'b1, {(DIST_W-1){1'b0}}};
        end
        else
        begin
            d_sat = q_full_w[DIST_W-1:0];
        end
    end

    // edge classification
    vec3_t                    bfirst;
    logic signed [DIST_W-1:0] bfirst_d;
    logic [4:0]               mask_next;
    assign bfirst   = have_first_reg ? first_v_reg : v_reg;
    assign bfirst_d = have_first_reg ? first_d_reg : d_reg;
    assign mask_next[0] = have_first_reg && keep_f(prev_d_reg, cfg.tol);
    assign mask_next[1] = have_first_reg && cross_f(prev_d_reg, d_reg, cfg.tol);
    assign mask_next[2] = closes_reg && keep_f(d_reg, cfg.tol);
    assign mask_next[3] = closes_reg && cross_f(d_reg, bfirst_d, cfg.tol);
    assign mask_next[4] = closes_reg;

    // work entry for the current step; last when no later step is pending
    logic more;
    always_comb
    begin
        more = 1'b0;
        for (int j = 0; j < 5; j++)
        begin
            if ((3'(j) > step_reg) && mask_reg[j])
            begin
                more = 1'b1;
            end
        end
    end

    always_comb
    begin
        q_entry       = '0;
        q_entry.last  = !more;
        q_entry.few   = (cnt_reg < CNT_W'(MIN_KEPT));
        q_entry.count = cnt_reg;
        case (step_reg)
            3'd0:
            begin
                q_entry.kind = OP_POINT;
                q_entry.a    = e1a_reg;
            end
            3'd1:
            begin
                q_entry.kind = OP_CROSS;
                q_entry.a    = e1a_reg;
                q_entry.b    = v_reg;
                q_entry.na   = abs_f(e1d_reg);
                q_entry.nb   = abs_f(d_reg);
            end
            3'd2:
            begin
                q_entry.kind = OP_POINT;
                q_entry.a    = v_reg;
            end
            3'd3:
            begin
                q_entry.kind = OP_CROSS;
                q_entry.a    = v_reg;
                q_entry.b    = e2b_reg;
                q_entry.na   = abs_f(d_reg);
                q_entry.nb   = abs_f(e2d_reg);
            end
            default:
            begin
                q_entry.kind = OP_STATUS;
            end
        endcase
    end

    logic advance;
    assign in_ready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && mask_reg[step_reg] && !q_full;
    assign advance  = (state_reg == F_PUSH) && (!mask_reg[step_reg] || !q_full);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            have_first_reg <= 1'b0;
            cnt_reg        <= '0;
            first_v_reg    <= '0;
            first_d_reg    <= '0;
            prev_v_reg     <= '0;
            prev_d_reg     <= '0;
            mcnt_reg       <= '0;
            step_reg       <= '0;
            mask_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        v_reg      <= in_vertex;
                        closes_reg <= in_closes;
                        acc_reg    <= '0;
                        mcnt_reg   <= 2'd0;
                        state_reg  <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    prod_reg <= diff * inw;
                    if (mcnt_reg != 2'd0)
                    begin
                        acc_reg <= acc_reg + 53'(prod_reg);
                    end
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3)
                    begin
                        state_reg <= F_DIST;
                    end
                end
                F_DIST:
                begin
                    d_reg     <= d_sat;
                    state_reg <= F_CLASS;
                end
                F_CLASS:
                begin
                    e1a_reg  <= prev_v_reg;
                    e1d_reg  <= prev_d_reg;
                    e2b_reg  <= bfirst;
                    e2d_reg  <= bfirst_d;
                    mask_reg <= mask_next;
                    step_reg <= 3'd0;
                    if (!have_first_reg)
                    begin
                        first_v_reg <= v_reg;
                        first_d_reg <= d_reg;
                    end
                    prev_v_reg     <= v_reg;
                    prev_d_reg     <= d_reg;
                    have_first_reg <= !closes_reg;
                    state_reg      <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (q_push)
                    begin
                        if (step_reg == 3'd4)
                        begin
                            cnt_reg <= '0;
                        end
                        else if (cnt_reg < CNT_W'(COUNT_CAP))
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                    if (advance)
                    begin
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd4)
                        begin
                            state_reg <= F_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/phsc_back.sv =====
// Clipper back end: drains queued work, runs the crossing divide and
// interpolation, and holds the output register.
// Depends on phsc_pkg.
`timescale 1ns / 1ps

module phsc_back
    import phsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  entry_t        q_head,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_MUL,
        B_PUT
    } bstate_t;

    bstate_t              state_reg;
    vec3_t                a_reg;
    vec3_t                b_reg;
    logic [DIST_W:0]      den_reg;
    logic [DIST_W:0]      rem_reg;
    logic [T_BITS-1:0]    quo_reg;
    logic [4:0]           dcnt_reg;
    logic [1:0]           mcnt_reg;
    logic [61:0]          prod_reg;
    vec3_t                res_reg;
    logic                 last_reg;
    logic                 out_valid_reg;
    vec3_t                out_pt_reg;
    logic                 out_kind_reg;
    logic                 out_few_reg;
    logic [CNT_W-1:0]     out_cnt_reg;
    logic                 out_last_reg;

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // restoring divide step
    logic [DIST_W+1:0] rem2;
    logic              fits;
    assign rem2 = {rem_reg, 1'b0};
    assign fits = rem2 >= {1'b0, den_reg};

    // coordinate difference for the product now issued and the one finishing
    logic [1:0]         pidx;
    logic [1:0]         ridx;
    logic signed [32:0] pdiff;
    logic signed [32:0] rdiff;
    logic [31:0]        pmag;
    logic [62:0]        rounded;
    logic [31:0]        off;
    assign pidx  = (mcnt_reg == 2'd3) ? 2'd2 : mcnt_reg;
    assign ridx  = (mcnt_reg == 2'd0) ? 2'd0 : (mcnt_reg - 2'd1);
    assign pdiff = $signed({b_reg[pidx][31], b_reg[pidx]})
                 - $signed({a_reg[pidx][31], a_reg[pidx]});
    assign rdiff = $signed({b_reg[ridx][31], b_reg[ridx]})
                 - $signed({a_reg[ridx][31], a_reg[ridx]});
    assign pmag  = pdiff[32] ? 32'(-pdiff) : 32'(pdiff);
    assign rounded = {1'b0, prod_reg} + (63'd1 << (T_BITS - 1));
    assign off     = rounded[T_BITS +: 32];

    assign q_pop = (state_reg == B_IDLE) && !q_empty
                 && ((q_head.kind == OP_CROSS) || out_free);

    // output register loads a new beat
    logic out_load;
    assign out_load = ((state_reg == B_IDLE) && q_pop && (q_head.kind != OP_CROSS))
                    || ((state_reg == B_PUT) && out_free);

    // work sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            mcnt_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_head.kind == OP_CROSS)
                        begin
                            a_reg     <= q_head.a;
                            b_reg     <= q_head.b;
                            den_reg   <= {1'b0, q_head.na} + {1'b0, q_head.nb};
                            rem_reg   <= {1'b0, q_head.na};
                            quo_reg   <= '0;
                            last_reg  <= q_head.last;
                            dcnt_reg  <= '0;
                            state_reg <= B_DIV;
                        end
                        else
                        begin
                            out_last_reg  <= q_head.last;
                            if (q_head.kind == OP_STATUS)
                            begin
                                out_pt_reg   <= '0;
                                out_kind_reg <= ITEM_STATUS;
                                out_few_reg  <= q_head.few;
                                out_cnt_reg  <= q_head.count;
                            end
                            else
                            begin
                                out_pt_reg   <= q_head.a;
                                out_kind_reg <= ITEM_POINT;
                                out_few_reg  <= 1'b0;
                                out_cnt_reg  <= '0;
                            end
                        end
                    end
                end
                B_DIV:
                begin
                    quo_reg <= {quo_reg[T_BITS-2:0], fits};
                    rem_reg <= fits ? (DIST_W+1)'(rem2 - {1'b0, den_reg})
                                    : rem2[DIST_W:0];
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'(T_BITS - 1))
                    begin
                        mcnt_reg  <= 2'd0;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    prod_reg <= 62'(pmag) * 62'(quo_reg);
                    if (mcnt_reg != 2'd0)
                    begin
                        res_reg[ridx] <= rdiff[32] ? (a_reg[ridx] - off)
                                                   : (a_reg[ridx] + off);
                    end
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3)
                    begin
                        state_reg <= B_PUT;
                    end
                end
                B_PUT:
                begin
                    if (out_free)
                    begin
                        out_pt_reg    <= res_reg;
                        out_kind_reg  <= ITEM_POINT;
                        out_few_reg   <= 1'b0;
                        out_cnt_reg   <= '0;
                        out_last_reg  <= last_reg;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_cnt_reg, out_few_reg,
                       out_pt_reg[2], out_pt_reg[1], out_pt_reg[0]};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ITEM_STATUS) |-> m_tlast)
        else $error("status beat not last of run");

    a_few_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ITEM_STATUS)
            |-> (out_few_reg == (out_cnt_reg < CNT_W'(MIN_KEPT))))
        else $error("too_few_points disagrees with count");

    a_point_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ITEM_POINT) |-> (out_cnt_reg == '0 && !out_few_reg))
        else $error("point beat carries status fields");

endmodule

// ===== tb/sv/polygon_half_space_clip_test.sv =====
// Testbench for polygon_half_space_clip: streams polygons through the clipper and
// checks every output beat against an in-bench fixed-point clip predictor or typed beats.
// Depends on phsc_pkg and the polygon_half_space_clip RTL.
`timescale 1ns / 1ps

module polygon_half_space_clip_test;
    import phsc_pkg::*;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        kind;
        logic        few;
        logic [11:0] cnt;
        logic        last;
    } clip_beat_t;

    typedef struct {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        closes;
        logic        typed;     // expected beats given in the row
        int          nexp;
        clip_beat_t  exp0;
        clip_beat_t  exp1;
    } vertex_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;     // vertex_x, vertex_y, vertex_z
    logic         s_tlast;     // closes_polygon
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;     // point_x, point_y, point_z, too_few_points, kept_count
    logic         m_tuser;     // item_kind
    logic         m_tlast;     // last_of_run
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    polygon_half_space_clip dut (.*);

    // predictor copy of configuration and state
    longint org_x, org_y, org_z, nrm_x, nrm_y, nrm_z, plane_off, band_tol;
    longint first_v[3], prev_v[3], first_d, prev_d;
    bit     have_first;
    int     kept_cnt;

    clip_beat_t expected_beats[$];
    int  fail_count;
    int  beats_checked;
    int  vertices_sent;
    bit  feeding_done;
    int  out_wait;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("polygon_half_space_clip verification failed");
        $finish;
    end

    function automatic longint plane_distance(longint vx, longint vy, longint vz);
        longint s;
        longint q;
        s = (vx - org_x) * nrm_x + (vy - org_y) * nrm_y + (vz - org_z) * nrm_z;
        if (s >= 0)
            q = s >>> FRACTION_BITS;
        else
            q = -((-s + (64'sd1 << FRACTION_BITS) - 1) >>> FRACTION_BITS);
        q = q - plane_off;
        if (q > 64'sd8589934591)
            q = 64'sd8589934591;
        if (q < -64'sd8589934592)
            q = -64'sd8589934592;
        return q;
    endfunction

    function automatic void queue_beat(clip_beat_t b);
        expected_beats = {expected_beats, b};
    endfunction

    function automatic void push_point(longint x, longint y, longint z);
        clip_beat_t b;
        b = '{x[31:0], y[31:0], z[31:0], ITEM_POINT, 1'b0, 12'd0, 1'b0};
        queue_beat(b);
        if (kept_cnt < COUNT_CAP)
            kept_cnt++;
    endfunction

    function automatic void clip_edge(longint a[3], longint da, longint b[3], longint db);
        longint unsigned na, nb, t, mag, off;
        longint diff;
        longint p[3];
        if (da >= -band_tol)
            push_point(a[0], a[1], a[2]);
        if ((da > band_tol && db < -band_tol) || (da < -band_tol && db > band_tol))
        begin
            na = da < 0 ? -da : da;
            nb = db < 0 ? -db : db;
            t = (na << T_BITS) / (na + nb);
            for (int k = 0; k < 3; k++)
            begin
                diff = b[k] - a[k];
                mag = diff < 0 ? -diff : diff;
                off = (mag * t + (64'd1 << (T_BITS - 1))) >> T_BITS;
                p[k] = diff < 0 ? a[k] - longint'(off) : a[k] + longint'(off);
            end
            push_point(p[0], p[1], p[2]);
        end
    endfunction

    // predicts the beats one vertex causes; returns their count
    function automatic int predict_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic closes);
        longint v[3];
        longint d;
        int before_n;
        clip_beat_t st;
        before_n = expected_beats.size();
        v[0] = longint'(signed'(x));
        v[1] = longint'(signed'(y));
        v[2] = longint'(signed'(z));
        d = plane_distance(v[0], v[1], v[2]);
        if (!have_first)
        begin
            first_v = v;
            first_d = d;
            have_first = 1'b1;
        end
        else
            clip_edge(prev_v, prev_d, v, d);
        prev_v = v;
        prev_d = d;
        if (closes)
        begin
            clip_edge(v, d, first_v, first_d);
            st = '{32'd0, 32'd0, 32'd0, ITEM_STATUS, kept_cnt < MIN_KEPT,
                   kept_cnt[11:0], 1'b0};
            queue_beat(st);
            have_first = 1'b0;
            kept_cnt = 0;
        end
        if (expected_beats.size() > before_n)
            expected_beats[$].last = 1'b1;
        return expected_beats.size() - before_n;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ORIGIN_X:  org_x = longint'(signed'(val));
            REG_ORIGIN_Y:  org_y = longint'(signed'(val));
            REG_ORIGIN_Z:  org_z = longint'(signed'(val));
            REG_INWARD_X:  nrm_x = longint'(signed'(val[17:0]));
            REG_INWARD_Y:  nrm_y = longint'(signed'(val[17:0]));
            REG_INWARD_Z:  nrm_z = longint'(signed'(val[17:0]));
            REG_OFFSET:    plane_off = longint'(signed'(val));
            REG_TOLERANCE: band_tol = longint'(val[15:0]);
            default:       band_tol = band_tol;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // one input beat after a random idle gap; tvalid stays up when the gap is zero
    task automatic drive_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic closes);
        int idle;
        idle = $urandom_range(0, 6);
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tlast  <= closes;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        vertices_sent++;
    endtask

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic closes);
        void'(predict_vertex(x, y, z, closes));
        drive_vertex(x, y, z, closes);
    endtask

    // random coordinate: mostly moderate, sometimes the full range
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 32'h00100000)) - 32'sh00080000);
    endfunction

    task automatic send_polygon(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
    endtask

    // output side: per-beat stall count and field checks
    always @(posedge clk)
    begin
        clip_beat_t e;
        clip_beat_t got;
        int w;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser,
                    m_tdata[96], m_tdata[108:97], m_tlast};
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat %p", $time, got);
                fail_count++;
            end
            else
            begin
                e = expected_beats.pop_front();
                if (got !== e)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, got);
                    fail_count++;
                end
            end
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            w = feeding_done ? 0 : $urandom_range(0, 6);
            out_wait <= w;
            m_tready <= (w == 0);
        end
        else if (!m_tready)
        begin
            if (out_wait > 1)
                out_wait <= out_wait - 1;
            else
                m_tready <= 1'b1;
        end
    end

    vertex_row_t dir_rows[$];
    clip_beat_t  zb;

    function automatic void queue_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic closes);
        vertex_row_t r;
        r = '{x, y, z, closes, 1'b0, 0, zb, zb};
        dir_rows = {dir_rows, r};
    endfunction

    initial
    begin
        int nbeats;
        vertex_row_t r;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        fail_count = 0;
        beats_checked = 0;
        vertices_sent = 0;
        feeding_done = 1'b0;
        org_x = 0; org_y = 0; org_z = 0;
        nrm_x = 0; nrm_y = 0; nrm_z = 65536;
        plane_off = 0; band_tol = 1;
        have_first = 1'b0;
        kept_cnt = 0;
        first_v = '{0, 0, 0}; prev_v = '{0, 0, 0};
        first_d = 0; prev_d = 0;
        zb = '{32'd0, 32'd0, 32'd0, ITEM_POINT, 1'b0, 12'd0, 1'b0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: reset registers, z above plane kept
        // single closing vertex above plane: the point then status
        r = '{32'd0, 32'd0, 32'h00010000, 1'b1, 1'b1, 2, zb, zb};
        r.exp0.pz = 32'h00010000; r.exp0.last = 1'b0;
        r.exp1 = '{0, 0, 0, ITEM_STATUS, 1'b1, 12'd1, 1'b1};
        dir_rows = {dir_rows, r};
        // single vertex far below: only the status
        r = '{32'd0, 32'd0, 32'h80000000, 1'b1, 1'b1, 1, zb, zb};
        r.exp0 = '{0, 0, 0, ITEM_STATUS, 1'b1, 12'd0, 1'b1};
        dir_rows = {dir_rows, r};
        // first vertex on the plane, no beats
        r = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 0, zb, zb};
        dir_rows = {dir_rows, r};
        // extremes and a crossing quadrilateral, predictor checked
        queue_row(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        queue_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1);
        queue_row(32'h00010000, 32'd0, 32'h00050000, 1'b0);
        queue_row(32'h00030000, 32'd0, 32'hFFFB0000, 1'b0);
        queue_row(32'hFFFF0000, 32'h00020000, 32'hFFFD0000, 1'b0);
        queue_row(32'h00020000, 32'h00010000, 32'h00040000, 1'b1);
        // vertices inside and just outside the tolerance band
        queue_row(32'd5, 32'd5, 32'd1, 1'b0);
        queue_row(32'd7, 32'd7, 32'hFFFFFFFF, 1'b0);
        queue_row(32'd9, 32'd9, 32'hFFFFFFFE, 1'b1);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].typed)
            begin
                nbeats = predict_vertex(dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].vz,
                                        dir_rows[i].closes);
                // swap the predicted beats for the typed ones
                repeat (nbeats) void'(expected_beats.pop_back());
                if (dir_rows[i].nexp > 0)
                    queue_beat(dir_rows[i].exp0);
                if (dir_rows[i].nexp > 1)
                    queue_beat(dir_rows[i].exp1);
                drive_vertex(dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].vz,
                             dir_rows[i].closes);
            end
            else
                send_vertex(dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].vz, dir_rows[i].closes);
        end
        wait_drained();

        // extreme register settings, every register written
        write_reg(REG_ORIGIN_X, 32'h80000000);
        write_reg(REG_ORIGIN_Y, 32'h7FFFFFFF);
        write_reg(REG_ORIGIN_Z, 32'h00010000);
        write_reg(REG_INWARD_X, 32'h00010000);
        write_reg(REG_INWARD_Y, 32'h3FFFF);   // -1 raw, 18 bits
        write_reg(REG_INWARD_Z, 32'h30000);   // -65536
        write_reg(REG_OFFSET, 32'h80000000);
        write_reg(REG_TOLERANCE, 32'd65535);
        send_polygon(3);
        send_polygon(4);
        wait_drained();
        write_reg(REG_OFFSET, 32'h7FFFFFFF);
        write_reg(REG_TOLERANCE, 32'd0);
        send_polygon(3);
        wait_drained();

        // random phases with ordinary planes
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_ORIGIN_X, rand_coord());
            write_reg(REG_ORIGIN_Y, rand_coord());
            write_reg(REG_ORIGIN_Z, rand_coord());
            write_reg(REG_INWARD_X, 32'($urandom_range(0, 131072) - 65536));
            write_reg(REG_INWARD_Y, 32'($urandom_range(0, 131072) - 65536));
            write_reg(REG_INWARD_Z, 32'($urandom_range(0, 131072) - 65536));
            write_reg(REG_OFFSET, 32'($urandom_range(0, 32'h40000) - 32'h20000));
            write_reg(REG_TOLERANCE, (ph == 3) ? 32'd65535 : $urandom_range(0, 64));
            for (int p = 0; p < 6; p++)
                send_polygon($urandom_range(1, 7));
            wait_drained();
        end

        feeding_done = 1'b1;
        wait_drained();
        $display("Sent %0d vertices over several plane settings; checked %0d output beats.",
                 vertices_sent, beats_checked);
        if (fail_count == 0 && expected_beats.size() == 0)
            $display("polygon_half_space_clip verification clean");
        else
            $display("polygon_half_space_clip verification failed");
        $finish;
    end

endmodule
